// File: rtl/ncst_pkg.sv
// package for the named counting semaphore table
// holds sizes, status and request codes, item structs; no dependencies
`default_nettype none
package ncst_pkg;
    localparam int NUM_SEMS    = 16;
    localparam int NAME_BYTES  = 8;
    localparam int NUM_THREADS = 32;
    localparam int WAIT_DEPTH  = 8;
    localparam int COUNT_BITS  = 16;

    localparam int SEM_W   = $clog2(NUM_SEMS);
    localparam int THR_W   = 5;
    localparam int WPTR_W  = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int WFILL_W = $clog2(WAIT_DEPTH + 1);
    localparam int SLOT_AW = SEM_W + WPTR_W;
    localparam int SLOT_D  = NUM_SEMS * (1 << WPTR_W);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [7:0] REFS_MAX = 8'hff;

    localparam logic [1:0] REQ_CREATE  = 2'd0;
    localparam logic [1:0] REQ_P       = 2'd1;
    localparam logic [1:0] REQ_V       = 2'd2;
    localparam logic [1:0] REQ_DESTROY = 2'd3;

    localparam logic [2:0] ST_DONE     = 3'd0;
    localparam logic [2:0] ST_INVALID  = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_BLOCKED  = 3'd3;
    localparam logic [2:0] ST_QFULL    = 3'd4;
    localparam logic [2:0] ST_WOKEN    = 3'd5;
    localparam logic [2:0] ST_RELEASED = 3'd6;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [4:0]  thread_id;
        logic [3:0]  sem_id;
        logic [63:0] sem_name;
        logic [3:0]  name_length;
        logic [15:0] init_count;
    } req_item_t;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] sem_out;
        logic [4:0] thread_out;
        logic       last;
    } rsp_item_t;
endpackage
`default_nettype wire

// File: rtl/named_counting_semaphore_table.sv
// named counting semaphore table top level: sequencer, entry registers, wait ram
// uses ncst_pkg and ncst_ram
// create scans the entries in S_SCAN (one entry compared per cycle), then runs S_EXEC
// p/v/destroy go straight to S_EXEC; s_ready low until the last result is taken
// each wake result of v or destroy adds a pass through S_RDW and S_WAKE (one wait ram read each)
// synchronous active low reset frees all entries and empties all queues
`default_nettype none
module named_counting_semaphore_table (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire ncst_pkg::req_item_t s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output ncst_pkg::rsp_item_t      m_data
);
    localparam int SW = ncst_pkg::SEM_W;
    localparam int PW = ncst_pkg::WPTR_W;
    localparam int FW = ncst_pkg::WFILL_W;
    localparam int CB = ncst_pkg::COUNT_BITS;
    localparam int NT = ncst_pkg::NUM_THREADS;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_EXEC  = 3'd2;
    localparam logic [2:0] S_OUT   = 3'd3;
    localparam logic [2:0] S_RDW   = 3'd4;
    localparam logic [2:0] S_WAKE  = 3'd5;

    logic [2:0] state_reg, state_next;
    ncst_pkg::req_item_t req_reg;
    logic [63:0] name_reg;
    logic [SW:0] idx_reg;
    logic found_reg, free_ok_reg;
    logic [SW-1:0] free_reg;

    logic [ncst_pkg::NUM_SEMS-1:0] in_use_reg;
    logic [63:0] ename_reg [ncst_pkg::NUM_SEMS];
    logic [CB-1:0] count_reg [ncst_pkg::NUM_SEMS];
    logic [7:0] refs_reg [ncst_pkg::NUM_SEMS];
    logic [NT-1:0] owner_reg [ncst_pkg::NUM_SEMS];
    logic [PW-1:0] head_reg [ncst_pkg::NUM_SEMS];
    logic [FW-1:0] fill_reg [ncst_pkg::NUM_SEMS];

    ncst_pkg::rsp_item_t out_reg, out_next;
    logic out_valid_reg;
    logic more_reg, more_next;

    logic we;
    logic [ncst_pkg::SLOT_AW-1:0] waddr, raddr;
    logic [4:0] rdata;

    logic [SW-1:0] sid;
    logic [63:0] mask;
    logic thr_bad;
    logic len_bad;
    logic [NT-1:0] tbit;
    logic [CB-1:0] init_sat;

    assign sid = req_reg.sem_id[SW-1:0];
    assign thr_bad = {27'd0, req_reg.thread_id} >= 32'(ncst_pkg::NUM_THREADS);
    assign len_bad = req_reg.name_length == 4'd0
        || {28'd0, req_reg.name_length} > 32'(ncst_pkg::NAME_BYTES);
    assign tbit = NT'(1) << req_reg.thread_id;
    assign init_sat = ({16'd0, req_reg.init_count} > 32'(ncst_pkg::COUNT_MAX))
        ? ncst_pkg::COUNT_MAX : CB'(req_reg.init_count);

    always_comb begin
        mask = '0;
        for (int b = 0; b < 8; b++) begin
            if (4'(b) < s_data.name_length) mask[b*8 +: 8] = 8'hff;
        end
    end

    ncst_ram #(.WIDTH(5), .DEPTH(ncst_pkg::SLOT_D)) u_wait (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(req_reg.thread_id),
        .raddr(raddr), .rdata(rdata)
    );

    assign s_ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    logic op_ok;
    assign op_ok = ({28'd0, req_reg.sem_id} < 32'(ncst_pkg::NUM_SEMS)) && in_use_reg[sid]
        && owner_reg[sid][req_reg.thread_id];

    assign we = (state_reg == S_EXEC) && op_ok && !thr_bad && req_reg.req_type == ncst_pkg::REQ_P
        && count_reg[sid] == '0 && {{(32-FW){1'b0}}, fill_reg[sid]} < 32'(ncst_pkg::WAIT_DEPTH);
    assign waddr = {sid, PW'((32'(head_reg[sid]) + 32'(fill_reg[sid]))
        % ncst_pkg::WAIT_DEPTH)};
    assign raddr = {sid, head_reg[sid]};

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (s_valid && s_ready) state_next = (s_data.req_type ==
                ncst_pkg::REQ_CREATE) ? S_SCAN : S_EXEC;
            S_SCAN: if (idx_reg == (SW+1)'(ncst_pkg::NUM_SEMS)) state_next = S_EXEC;
            S_EXEC: state_next = S_OUT;
            S_OUT: if (!out_valid_reg || m_ready) state_next = more_reg ? S_RDW : S_IDLE;
            S_RDW: state_next = S_WAKE;
            S_WAKE: state_next = S_OUT;
            default: state_next = S_IDLE;
        endcase
    end

    // reply of the request, then one wake result per pass through S_WAKE
    always_comb begin
        out_next = out_reg;
        more_next = more_reg;
        if (state_reg == S_EXEC) begin
            more_next = 1'b0;
            out_next.last = 1'b1;
            out_next.thread_out = req_reg.thread_id;
            out_next.sem_out = req_reg.sem_id;
            out_next.status = ncst_pkg::ST_DONE;
            if (thr_bad) begin
                out_next.status = ncst_pkg::ST_INVALID;
                if (req_reg.req_type == ncst_pkg::REQ_CREATE) out_next.sem_out = '0;
            end else if (req_reg.req_type == ncst_pkg::REQ_CREATE) begin
                out_next.sem_out = 4'(free_reg);
                if (len_bad) begin
                    out_next.status = ncst_pkg::ST_INVALID;
                    out_next.sem_out = '0;
                end else if (!found_reg && !free_ok_reg) begin
                    out_next.status = ncst_pkg::ST_FULL;
                    out_next.sem_out = '0;
                end
            end else if (!op_ok) begin
                out_next.status = ncst_pkg::ST_INVALID;
            end else if (req_reg.req_type == ncst_pkg::REQ_P) begin
                if (count_reg[sid] == '0) begin
                    out_next.status = we ? ncst_pkg::ST_BLOCKED : ncst_pkg::ST_QFULL;
                end
            end else if (req_reg.req_type == ncst_pkg::REQ_V) begin
                if (fill_reg[sid] != '0) begin
                    more_next = 1'b1;
                    out_next.last = 1'b0;
                end
            end else begin
                if (refs_reg[sid] <= 8'd1 && fill_reg[sid] != '0) begin
                    more_next = 1'b1;
                    out_next.last = 1'b0;
                end
            end
        end else if (state_reg == S_WAKE) begin
            out_next.status = (req_reg.req_type == ncst_pkg::REQ_V)
                ? ncst_pkg::ST_WOKEN : ncst_pkg::ST_RELEASED;
            out_next.sem_out = req_reg.sem_id;
            out_next.thread_out = rdata;
            if (req_reg.req_type == ncst_pkg::REQ_V || fill_reg[sid] == FW'(1)) begin
                more_next = 1'b0;
                out_next.last = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
            in_use_reg <= '0;
            more_reg <= 1'b0;
            for (int i = 0; i < ncst_pkg::NUM_SEMS; i++) begin
                owner_reg[i] <= '0;
                head_reg[i] <= '0;
                fill_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            case (state_reg)
                S_IDLE: begin
                    if (s_valid && s_ready) begin
                        req_reg <= s_data;
                        name_reg <= s_data.sem_name & mask;
                        idx_reg <= '0;
                        found_reg <= 1'b0;
                        free_ok_reg <= 1'b0;
                        free_reg <= '0;
                    end
                end
                S_SCAN: begin
                    if (idx_reg != (SW+1)'(ncst_pkg::NUM_SEMS)) begin
                        if (!found_reg && in_use_reg[idx_reg[SW-1:0]]
                                && ename_reg[idx_reg[SW-1:0]] == name_reg) begin
                            found_reg <= 1'b1;
                            free_reg <= idx_reg[SW-1:0];
                        end else if (!found_reg && !free_ok_reg
                                && !in_use_reg[idx_reg[SW-1:0]]) begin
                            free_ok_reg <= 1'b1;
                            free_reg <= idx_reg[SW-1:0];
                        end
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_EXEC: begin
                    out_reg <= out_next;
                    more_reg <= more_next;
                    out_valid_reg <= 1'b1;
                    if (!thr_bad && req_reg.req_type == ncst_pkg::REQ_CREATE && !len_bad) begin
                        if (found_reg) begin
                            if (refs_reg[free_reg] < ncst_pkg::REFS_MAX)
                                refs_reg[free_reg] <= refs_reg[free_reg] + 8'd1;
                            owner_reg[free_reg] <= owner_reg[free_reg] | tbit;
                        end else if (free_ok_reg) begin
                            in_use_reg[free_reg] <= 1'b1;
                            ename_reg[free_reg] <= name_reg;
                            count_reg[free_reg] <= init_sat;
                            refs_reg[free_reg] <= 8'd1;
                            owner_reg[free_reg] <= tbit;
                            head_reg[free_reg] <= '0;
                            fill_reg[free_reg] <= '0;
                        end
                    end else if (!thr_bad && req_reg.req_type != ncst_pkg::REQ_CREATE
                            && op_ok) begin
                        if (req_reg.req_type == ncst_pkg::REQ_P) begin
                            if (count_reg[sid] != '0) begin
                                count_reg[sid] <= count_reg[sid] - 1'b1;
                            end else if (we) begin
                                fill_reg[sid] <= fill_reg[sid] + 1'b1;
                            end
                        end else if (req_reg.req_type == ncst_pkg::REQ_V) begin
                            if (fill_reg[sid] == '0 && count_reg[sid] != ncst_pkg::COUNT_MAX)
                                count_reg[sid] <= count_reg[sid] + 1'b1;
                        end else begin
                            if (refs_reg[sid] <= 8'd1) begin
                                refs_reg[sid] <= '0;
                                in_use_reg[sid] <= 1'b0;
                                owner_reg[sid] <= '0;
                                if (fill_reg[sid] == '0) head_reg[sid] <= '0;
                            end else begin
                                refs_reg[sid] <= refs_reg[sid] - 8'd1;
                                owner_reg[sid] <= owner_reg[sid] & ~tbit;
                            end
                        end
                    end
                end
                S_OUT: begin
                    if (m_ready) out_valid_reg <= 1'b0;
                end
                S_RDW: ;
                S_WAKE: begin
                    out_reg <= out_next;
                    more_reg <= more_next;
                    out_valid_reg <= 1'b1;
                    fill_reg[sid] <= fill_reg[sid] - 1'b1;
                    head_reg[sid] <= (req_reg.req_type == ncst_pkg::REQ_DESTROY
                        && fill_reg[sid] == FW'(1)) ? '0
                        : PW'((32'(head_reg[sid]) + 1) % ncst_pkg::WAIT_DEPTH);
                end
                default: ;
            endcase
        end
    end

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> state_reg == S_IDLE) else $error("ready outside idle");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data)) else $error("result dropped");
    a_wake_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_WAKE |=> m_valid) else $error("wake result missing");
endmodule
`default_nettype wire

// File: rtl/ncst_ram.sv
// generic single port write, single port registered read ram
// no dependencies
`default_nettype none
module ncst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// File: tb/sv/testbench.sv
// testbench for the named counting semaphore table
// directed table, table and queue fill, then random requests, checked against an in-file predictor
// depends on ncst_pkg and named_counting_semaphore_table
`timescale 1ns / 100ps
`default_nettype none
module testbench;
    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    ncst_pkg::req_item_t s_data = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    ncst_pkg::rsp_item_t m_data;

    named_counting_semaphore_table u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // predictor state
    logic                            sem_used [ncst_pkg::NUM_SEMS];
    logic [63:0]                     sem_nm   [ncst_pkg::NUM_SEMS];
    logic [ncst_pkg::COUNT_BITS-1:0] sem_cnt  [ncst_pkg::NUM_SEMS];
    logic [7:0]                      sem_refs [ncst_pkg::NUM_SEMS];
    logic [31:0]                     sem_own  [ncst_pkg::NUM_SEMS];
    logic [4:0]                      waiters  [ncst_pkg::NUM_SEMS][$];

    ncst_pkg::rsp_item_t expected_rsp[$];
    int                  mismatches = 0;
    bit                  idle_on = 1'b1;

    function automatic ncst_pkg::rsp_item_t mk(logic [2:0] st, logic [3:0] sm, logic [4:0] th);
        ncst_pkg::rsp_item_t r;
        r.status = st; r.sem_out = sm; r.thread_out = th; r.last = 1'b0;
        return r;
    endfunction

    task automatic predict_request(input ncst_pkg::req_item_t q);
        ncst_pkg::rsp_item_t res[$];
        logic [63:0]         nm;
        logic [31:0]         tb;
        int                  hit;
        int                  s;
        hit = -1;
        tb = 32'd1 << q.thread_id;
        s = int'(q.sem_id);
        if (q.req_type == ncst_pkg::REQ_CREATE) begin
            if (q.name_length == 0 || q.name_length > ncst_pkg::NAME_BYTES) begin
                res.push_back(mk(ncst_pkg::ST_INVALID, 4'd0, q.thread_id));
            end else begin
                nm = (q.name_length >= 8) ? q.sem_name
                     : q.sem_name & ((64'd1 << (8 * q.name_length)) - 64'd1);
                for (int i = 0; i < ncst_pkg::NUM_SEMS; i++)
                    if (hit < 0 && sem_used[i] && sem_nm[i] == nm) hit = i;
                if (hit >= 0) begin
                    if (sem_refs[hit] != ncst_pkg::REFS_MAX) sem_refs[hit]++;
                    sem_own[hit] |= tb;
                    res.push_back(mk(ncst_pkg::ST_DONE, hit[3:0], q.thread_id));
                end else begin
                    for (int i = 0; i < ncst_pkg::NUM_SEMS; i++)
                        if (hit < 0 && !sem_used[i]) hit = i;
                    if (hit < 0) begin
                        res.push_back(mk(ncst_pkg::ST_FULL, 4'd0, q.thread_id));
                    end else begin
                        sem_used[hit] = 1'b1; sem_nm[hit] = nm;
                        sem_cnt[hit] = q.init_count; sem_refs[hit] = 8'd1;
                        sem_own[hit] = tb; waiters[hit].delete();
                        res.push_back(mk(ncst_pkg::ST_DONE, hit[3:0], q.thread_id));
                    end
                end
            end
        end else if (!sem_used[s] || (sem_own[s] & tb) == 0) begin
            res.push_back(mk(ncst_pkg::ST_INVALID, q.sem_id, q.thread_id));
        end else if (q.req_type == ncst_pkg::REQ_P) begin
            if (sem_cnt[s] != 0) begin
                sem_cnt[s]--;
                res.push_back(mk(ncst_pkg::ST_DONE, q.sem_id, q.thread_id));
            end else if (waiters[s].size() < ncst_pkg::WAIT_DEPTH) begin
                waiters[s].push_back(q.thread_id);
                res.push_back(mk(ncst_pkg::ST_BLOCKED, q.sem_id, q.thread_id));
            end else begin
                res.push_back(mk(ncst_pkg::ST_QFULL, q.sem_id, q.thread_id));
            end
        end else if (q.req_type == ncst_pkg::REQ_V) begin
            res.push_back(mk(ncst_pkg::ST_DONE, q.sem_id, q.thread_id));
            if (waiters[s].size() > 0)
                res.push_back(mk(ncst_pkg::ST_WOKEN, q.sem_id, waiters[s].pop_front()));
            else if (sem_cnt[s] != ncst_pkg::COUNT_MAX)
                sem_cnt[s]++;
        end else begin
            if (sem_refs[s] != 0) sem_refs[s]--;
            sem_own[s] &= ~tb;
            res.push_back(mk(ncst_pkg::ST_DONE, q.sem_id, q.thread_id));
            if (sem_refs[s] == 0) begin
                sem_used[s] = 1'b0; sem_own[s] = '0;
                while (waiters[s].size() > 0)
                    res.push_back(mk(ncst_pkg::ST_RELEASED, q.sem_id,
                                     waiters[s].pop_front()));
            end
        end
        res[res.size() - 1].last = 1'b1;
        foreach (res[i]) expected_rsp.push_back(res[i]);
    endtask

    task automatic send_request(input ncst_pkg::req_item_t q);
        while (idle_on && $urandom_range(99) < 12) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_data <= q;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_request(q);
    endtask

    // result side
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_rsp.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected item %p", m_data);
            end else begin
                if (m_data !== expected_rsp[0]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", expected_rsp[0], m_data);
                end
                void'(expected_rsp.pop_front());
            end
        end
        m_ready <= !(idle_on && $urandom_range(99) < 12);
    end

    function automatic ncst_pkg::req_item_t rq(logic [1:0] op, logic [4:0] th,
                                               logic [3:0] sm, logic [63:0] nm,
                                               logic [3:0] ln, logic [15:0] ic);
        ncst_pkg::req_item_t q;
        q.req_type = op; q.thread_id = th; q.sem_id = sm;
        q.sem_name = nm; q.name_length = ln; q.init_count = ic;
        return q;
    endfunction

    // directed rows; typed rows carry the expected reply status and index, checked against the predictor
    typedef struct {
        ncst_pkg::req_item_t q;
        logic                typed;
        logic [2:0]          st;
        logic [3:0]          sm;
    } dir_row_t;

    dir_row_t            dir_rows[$];
    ncst_pkg::req_item_t q;

    initial begin
        for (int i = 0; i < ncst_pkg::NUM_SEMS; i++) begin
            sem_used[i] = '0; sem_nm[i] = '0; sem_cnt[i] = '0;
            sem_refs[i] = '0; sem_own[i] = '0;
        end
        dir_rows = '{
            '{rq(ncst_pkg::REQ_P, 5'd0, 4'd0, 64'd0, 4'd1, 16'd0),
              1'b1, ncst_pkg::ST_INVALID, 4'd0},
            '{rq(ncst_pkg::REQ_CREATE, 5'd1, 4'd0, '1, 4'd0, 16'd1),
              1'b1, ncst_pkg::ST_INVALID, 4'd0},
            '{rq(ncst_pkg::REQ_CREATE, 5'd1, 4'd0, '1, 4'd9, 16'd1),
              1'b1, ncst_pkg::ST_INVALID, 4'd0},
            '{rq(ncst_pkg::REQ_CREATE, 5'd1, 4'd0, '1, 4'd15, 16'd1),
              1'b1, ncst_pkg::ST_INVALID, 4'd0},
            '{rq(ncst_pkg::REQ_CREATE, 5'd31, 4'd15, '1, 4'd8, 16'hffff),
              1'b1, ncst_pkg::ST_DONE, 4'd0},
            '{rq(ncst_pkg::REQ_CREATE, 5'd2, 4'd0, 64'hffff_ffff_ff41, 4'd1, 16'd0),
              1'b1, ncst_pkg::ST_DONE, 4'd1},
            '{rq(ncst_pkg::REQ_CREATE, 5'd3, 4'd0, 64'h41, 4'd2, 16'd5),
              1'b1, ncst_pkg::ST_DONE, 4'd1},
            '{rq(ncst_pkg::REQ_CREATE, 5'd4, 4'd0, 64'h7741, 4'd1, 16'd5),
              1'b1, ncst_pkg::ST_DONE, 4'd1},
            '{rq(ncst_pkg::REQ_V, 5'd31, 4'd0, 64'd0, 4'd1, 16'd0),
              1'b0, ncst_pkg::ST_DONE, 4'd0},
            '{rq(ncst_pkg::REQ_P, 5'd31, 4'd0, 64'd0, 4'd1, 16'd0),
              1'b0, ncst_pkg::ST_DONE, 4'd0},
            '{rq(ncst_pkg::REQ_P, 5'd2, 4'd1, 64'd0, 4'd1, 16'd0),
              1'b1, ncst_pkg::ST_BLOCKED, 4'd1},
            '{rq(ncst_pkg::REQ_P, 5'd4, 4'd1, 64'd0, 4'd1, 16'd0),
              1'b1, ncst_pkg::ST_BLOCKED, 4'd1},
            '{rq(ncst_pkg::REQ_P, 5'd5, 4'd1, 64'd0, 4'd1, 16'd0),
              1'b1, ncst_pkg::ST_INVALID, 4'd1},
            '{rq(ncst_pkg::REQ_V, 5'd2, 4'd1, 64'd0, 4'd1, 16'd0),
              1'b0, ncst_pkg::ST_DONE, 4'd0},
            '{rq(ncst_pkg::REQ_P, 5'd2, 4'd9, 64'd0, 4'd1, 16'd0),
              1'b1, ncst_pkg::ST_INVALID, 4'd9},
            '{rq(ncst_pkg::REQ_DESTROY, 5'd2, 4'd1, 64'd0, 4'd1, 16'd0),
              1'b0, ncst_pkg::ST_DONE, 4'd0},
            '{rq(ncst_pkg::REQ_DESTROY, 5'd4, 4'd1, 64'd0, 4'd1, 16'd0),
              1'b0, ncst_pkg::ST_DONE, 4'd0},
            '{rq(ncst_pkg::REQ_DESTROY, 5'd31, 4'd0, 64'd0, 4'd1, 16'd0),
              1'b0, ncst_pkg::ST_DONE, 4'd0},
            '{rq(ncst_pkg::REQ_DESTROY, 5'd3, 4'd2, 64'd0, 4'd1, 16'd0),
              1'b0, ncst_pkg::ST_DONE, 4'd0}
        };
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (dir_rows[i]) begin
            send_request(dir_rows[i].q);
            if (dir_rows[i].typed) begin
                ncst_pkg::rsp_item_t row_rsp;
                row_rsp = expected_rsp[expected_rsp.size() - 1];
                if (row_rsp.status !== dir_rows[i].st || row_rsp.sem_out !== dir_rows[i].sm) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("row %0d: table %0d/%0d predictor %0d/%0d", i,
                                 dir_rows[i].st, dir_rows[i].sm,
                                 row_rsp.status, row_rsp.sem_out);
                end
            end
        end
        // fill the table, then a wait queue to its limit and one past it, then destroy each index
        for (int i = 0; i < ncst_pkg::NUM_SEMS + 1; i++)
            send_request(rq(ncst_pkg::REQ_CREATE, 5'd6, 4'd0, 64'h1000 + i, 4'd8, 16'd0));
        for (int i = 0; i < ncst_pkg::WAIT_DEPTH + 1; i++)
            send_request(rq(ncst_pkg::REQ_P, 5'd6, 4'd3, 64'd0, 4'd1, 16'd0));
        for (int i = 0; i < ncst_pkg::NUM_SEMS; i++)
            send_request(rq(ncst_pkg::REQ_DESTROY, 5'd6, i[3:0], 64'd0, 4'd1, 16'd0));
        // random part: a small name pool and few threads keep most requests valid
        for (int n = 0; n < 100; n++) begin
            if (n == 40) idle_on = 1'b0;
            if (n == 75) idle_on = 1'b1;
            q.req_type = 2'($urandom_range(3));
            q.thread_id = 5'(($urandom_range(9) == 0) ? $urandom_range(31)
                             : $urandom_range(3));
            q.sem_id = 4'(($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(3));
            q.sem_name = {$urandom, $urandom};
            if ($urandom_range(3) != 0) q.sem_name[63:8] = 56'($urandom_range(3));
            q.name_length = 4'(($urandom_range(15) == 0) ? $urandom_range(15)
                               : $urandom_range(1, 8));
            q.init_count = 16'(($urandom_range(7) == 0) ? $urandom : $urandom_range(2));
            if (q.req_type == ncst_pkg::REQ_P && $urandom_range(1) != 0) q.sem_id = '0;
            send_request(q);
        end
        s_valid <= 1'b0;
        while (expected_rsp.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (mismatches == 0 && expected_rsp.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("== FAIL ==");
        $finish;
    end
endmodule
`default_nettype wire
